@@ hdl/grfc_pkg.sv @@
// ----------------------------------------------------------------------------
// grfc_pkg: shared codes and types for the guarded region fault catcher
// Action and verdict codes, table defaults and the table status word.
// ----------------------------------------------------------------------------
package grfc_pkg;

  localparam int REGION_SLOTS_DEFAULT = 4;

  localparam int ADDR_W   = 64;
  localparam int ACTION_W = 3;
  localparam int VERDICT_W = 2;
  localparam int SCOPE_W  = 32;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_REGISTER   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_UNREGISTER = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FAULT      = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_START      = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_END        = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CHECK      = 3'd5;

  // fault verdicts
  localparam logic [VERDICT_W-1:0] VERDICT_NONE   = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_CAUGHT = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_ABORT  = 2'd2;

  // what the region table reports for the word in the input register
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] hit_base;
    logic              full;
  } table_status_t;

endpackage

@@ hdl/grfc_region_table.sv @@
// ----------------------------------------------------------------------------
// grfc_region_table: guarded range table
// Holds base and length per slot, compares an address against every slot at
// once, and applies register and unregister updates.
// ----------------------------------------------------------------------------
module grfc_region_table #(
  parameter int REGION_SLOTS = grfc_pkg::REGION_SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [grfc_pkg::ACTION_W-1:0]  action,
  input  logic [grfc_pkg::ADDR_W-1:0]    address,
  input  logic [grfc_pkg::ADDR_W-1:0]    length,
  output grfc_pkg::table_status_t        status
);
  import grfc_pkg::*;

  logic [ADDR_W-1:0]       slot_base   [REGION_SLOTS];
  logic [ADDR_W-1:0]       slot_length [REGION_SLOTS];
  logic [REGION_SLOTS-1:0] free;
  logic [REGION_SLOTS-1:0] holds;
  logic [REGION_SLOTS-1:0] free_first;
  logic [REGION_SLOTS-1:0] hit_first;
  logic [ADDR_W-1:0]       base_sel;

  // range end taken at 65 bits
  always_comb begin
    for (int i = 0; i < REGION_SLOTS; i++) begin
      free[i]  = (slot_base[i] == '0) && (slot_length[i] == '0);
      holds[i] = (address >= slot_base[i]) &&
                 ({1'b0, address} < ({1'b0, slot_base[i]} + {1'b0, slot_length[i]}));
    end
  end

  // lowest set bit
  assign free_first = free  & (~free  + REGION_SLOTS'(1));
  assign hit_first  = holds & (~holds + REGION_SLOTS'(1));

  always_comb begin
    base_sel = '0;
    for (int i = 0; i < REGION_SLOTS; i++) begin
      if (hit_first[i]) begin
        base_sel = base_sel | slot_base[i];
      end
    end
  end

  assign status.hit      = |holds;
  assign status.hit_base = base_sel;
  assign status.full     = ~|free;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REGION_SLOTS; i++) begin
        slot_base[i]   <= '0;
        slot_length[i] <= '0;
      end
    end else if (step) begin
      for (int i = 0; i < REGION_SLOTS; i++) begin
        if (action == ACT_REGISTER && free_first[i]) begin
          slot_base[i]   <= address;
          slot_length[i] <= length;
        end else if (action == ACT_UNREGISTER && holds[i]) begin
          slot_base[i]   <= '0;
          slot_length[i] <= '0;
        end
      end
    end
  end

endmodule

@@ hdl/guarded_region_fault_catcher.sv @@
// ----------------------------------------------------------------------------
// guarded_region_fault_catcher: guarded range table with fault verdicts
// Each input word carries one action; each gives exactly one result word.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_ready with action, address and length.
// Output channel: out_valid / out_ready with verdict, table_full,
// fault_valid, fault_region_base and fault_address. Fields that do not
// apply to the action are zero.
// An accepted word is held in the input register, is judged against every
// slot in parallel, and lands in the result register, which presents it.
// One word per cycle is sustained while the receiver takes results; the
// single pass through the slot compares and the scope and latch update
// sets that figure.
// When the receiver stalls, the result register holds and the input
// register still takes one more word; in_ready then drops until the
// result is taken.
// Reset (rst, synchronous) empties both registers, clears every slot,
// the scope count and the fault latch; no word is taken in that cycle.
// ----------------------------------------------------------------------------
module guarded_region_fault_catcher #(
  parameter int REGION_SLOTS = grfc_pkg::REGION_SLOTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [grfc_pkg::ACTION_W-1:0]   action,
  input  logic [grfc_pkg::ADDR_W-1:0]     address,
  input  logic [grfc_pkg::ADDR_W-1:0]     length,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [grfc_pkg::VERDICT_W-1:0]  verdict,
  output logic                            table_full,
  output logic                            fault_valid,
  output logic [grfc_pkg::ADDR_W-1:0]     fault_region_base,
  output logic [grfc_pkg::ADDR_W-1:0]     fault_address
);
  import grfc_pkg::*;

  logic                 s1_valid;
  logic [ACTION_W-1:0]  s1_action;
  logic [ADDR_W-1:0]    s1_address;
  logic [ADDR_W-1:0]    s1_length;
  logic                 s1_fire;

  table_status_t        status;

  logic [SCOPE_W-1:0]   scope_count;
  logic [SCOPE_W-1:0]   scope_count_next;
  logic                 fault_latched;
  logic                 fault_latched_next;
  logic [ADDR_W-1:0]    first_fault_base;
  logic [ADDR_W-1:0]    first_fault_base_next;
  logic [ADDR_W-1:0]    first_fault_addr;
  logic [ADDR_W-1:0]    first_fault_addr_next;

  logic [VERDICT_W-1:0] verdict_next;
  logic                 table_full_next;
  logic                 fault_valid_next;
  logic [ADDR_W-1:0]    fault_region_base_next;
  logic [ADDR_W-1:0]    fault_address_next;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !rst && (!s1_valid || s1_fire);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_action  <= action;
      s1_address <= address;
      s1_length  <= length;
    end
  end

  grfc_region_table #(
    .REGION_SLOTS(REGION_SLOTS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_fire),
    .action  (s1_action),
    .address (s1_address),
    .length  (s1_length),
    .status  (status)
  );

  always_comb begin
    scope_count_next       = scope_count;
    fault_latched_next     = fault_latched;
    first_fault_base_next  = first_fault_base;
    first_fault_addr_next  = first_fault_addr;
    verdict_next           = VERDICT_NONE;
    table_full_next        = 1'b0;
    fault_valid_next       = 1'b0;
    fault_region_base_next = '0;
    fault_address_next     = '0;
    case (s1_action)
      ACT_REGISTER: begin
        table_full_next = status.full;
      end
      ACT_FAULT: begin
        if (!status.hit) begin
          verdict_next = VERDICT_NONE;
        end else if (scope_count == '0) begin
          verdict_next = VERDICT_ABORT;
        end else begin
          verdict_next = VERDICT_CAUGHT;
          if (!fault_latched) begin
            fault_latched_next    = 1'b1;
            first_fault_base_next = status.hit_base;
            first_fault_addr_next = s1_address;
          end
        end
      end
      ACT_START: begin
        if (scope_count != '1) begin
          scope_count_next = scope_count + SCOPE_W'(1);
        end
      end
      ACT_END: begin
        if (scope_count != '0) begin
          scope_count_next = scope_count - SCOPE_W'(1);
        end
      end
      ACT_CHECK: begin
        if (fault_latched) begin
          fault_valid_next       = 1'b1;
          fault_region_base_next = first_fault_base;
          fault_address_next     = first_fault_addr;
          fault_latched_next     = 1'b0;
          first_fault_base_next  = '0;
          first_fault_addr_next  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      scope_count      <= '0;
      fault_latched    <= 1'b0;
      first_fault_base <= '0;
      first_fault_addr <= '0;
    end else begin
      if (s1_fire) begin
        out_valid        <= 1'b1;
        scope_count      <= scope_count_next;
        fault_latched    <= fault_latched_next;
        first_fault_base <= first_fault_base_next;
        first_fault_addr <= first_fault_addr_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_fire) begin
      verdict           <= verdict_next;
      table_full        <= table_full_next;
      fault_valid       <= fault_valid_next;
      fault_region_base <= fault_region_base_next;
      fault_address     <= fault_address_next;
    end
  end

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid && !s1_valid)
    else $error("result register not empty after reset");

  a_check_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_action == ACT_CHECK |=> !fault_latched && first_fault_base == '0)
    else $error("fault latch not cleared by check");

  a_scope_floor: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_action == ACT_END && scope_count == '0 |=> scope_count == '0)
    else $error("scope count wrapped below zero");

  a_fields_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault_valid |-> verdict == VERDICT_NONE && !table_full)
    else $error("check result carries fault or register fields");

endmodule

@@ dv/grfc_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grfc_checker: result predictor and scoreboard for the fault catcher
// Watches both channels. Every accepted input word is run through a local
// copy of the region table, scope count and fault latch, and the expected
// result word is queued. Every accepted result word is compared field by
// field with the oldest queued expectation.
// ----------------------------------------------------------------------------
module grfc_checker #(
  parameter int REGION_SLOTS = grfc_pkg::REGION_SLOTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [grfc_pkg::ACTION_W-1:0]   action,
  input  logic [grfc_pkg::ADDR_W-1:0]     address,
  input  logic [grfc_pkg::ADDR_W-1:0]     length,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [grfc_pkg::VERDICT_W-1:0]  verdict,
  input  logic                            table_full,
  input  logic                            fault_valid,
  input  logic [grfc_pkg::ADDR_W-1:0]     fault_region_base,
  input  logic [grfc_pkg::ADDR_W-1:0]     fault_address,
  output int                              fail_count,
  output int                              pending
);

  import grfc_pkg::*;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic                 table_full;
    logic                 fault_valid;
    logic [ADDR_W-1:0]    exp_base;
    logic [ADDR_W-1:0]    exp_addr;
  } result_word_t;

  logic [ADDR_W-1:0]  region_start_q [REGION_SLOTS];
  logic [ADDR_W-1:0]  region_len_q [REGION_SLOTS];
  logic [SCOPE_W-1:0] scope_q;
  logic               latch_full_q;
  logic [ADDR_W-1:0]  latch_base_q;
  logic [ADDR_W-1:0]  latch_addr_q;

  result_word_t expected_words [$];

  function automatic logic region_holds(int idx, logic [ADDR_W-1:0] a);
    return (a >= region_start_q[idx]) && ((a - region_start_q[idx]) < region_len_q[idx]);
  endfunction

  function automatic result_word_t judge_word(logic [ACTION_W-1:0] act,
                                              logic [ADDR_W-1:0] a,
                                              logic [ADDR_W-1:0] len);
    result_word_t r;
    int hit;
    int i;
    r = '0;
    hit = -1;
    case (act)
      ACT_REGISTER: begin
        for (i = 0; i < REGION_SLOTS; i++)
          if (hit < 0 && region_start_q[i] == '0 && region_len_q[i] == '0)
            hit = i;
        if (hit < 0) begin
          r.table_full = 1'b1;
        end else begin
          region_start_q[hit] = a;
          region_len_q[hit] = len;
        end
      end
      ACT_UNREGISTER: begin
        for (i = 0; i < REGION_SLOTS; i++)
          if (region_holds(i, a)) begin
            region_start_q[i] = '0;
            region_len_q[i] = '0;
          end
      end
      ACT_FAULT: begin
        for (i = 0; i < REGION_SLOTS; i++)
          if (hit < 0 && region_holds(i, a))
            hit = i;
        if (hit < 0) begin
          r.verdict = VERDICT_NONE;
        end else if (scope_q == '0) begin
          r.verdict = VERDICT_ABORT;
        end else begin
          r.verdict = VERDICT_CAUGHT;
          if (!latch_full_q) begin
            latch_full_q = 1'b1;
            latch_base_q = region_start_q[hit];
            latch_addr_q = a;
          end
        end
      end
      ACT_START: begin
        if (scope_q != '1)
          scope_q = scope_q + SCOPE_W'(1);
      end
      ACT_END: begin
        if (scope_q != '0)
          scope_q = scope_q - SCOPE_W'(1);
      end
      ACT_CHECK: begin
        if (latch_full_q) begin
          r.fault_valid = 1'b1;
          r.exp_base = latch_base_q;
          r.exp_addr = latch_addr_q;
          latch_full_q = 1'b0;
          latch_base_q = '0;
          latch_addr_q = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_word_t want;
    int i;
    if (rst) begin
      for (i = 0; i < REGION_SLOTS; i++) begin
        region_start_q[i] = '0;
        region_len_q[i] = '0;
      end
      scope_q = '0;
      latch_full_q = 1'b0;
      latch_base_q = '0;
      latch_addr_q = '0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual verdict %0d",
                   $time, verdict);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          compare_field("verdict", ADDR_W'(want.verdict), ADDR_W'(verdict));
          compare_field("table_full", ADDR_W'(want.table_full), ADDR_W'(table_full));
          compare_field("fault_valid", ADDR_W'(want.fault_valid), ADDR_W'(fault_valid));
          compare_field("fault_region_base", want.exp_base, fault_region_base);
          compare_field("fault_address", want.exp_addr, fault_address);
        end
      end
      if (in_valid && in_ready)
        expected_words.push_back(judge_word(action, address, length));
    end
    pending <= expected_words.size();
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top level for the guarded region fault catcher
// Drives a directed pass over range edges, overlapping and full tables,
// the fault latch and scope limits, then random catch scopes built around
// registered regions with random faults and noise words. Both channels
// idle at random; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;

  import grfc_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
  localparam int RANDOM_WORDS = 1520;
  localparam int CYCLE_LIMIT  = 600000;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ACTION_W-1:0]   action = ACT_REGISTER;
  logic [ADDR_W-1:0]     address = '0;
  logic [ADDR_W-1:0]     length = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VERDICT_W-1:0]  verdict;
  logic                  table_full;
  logic                  fault_valid;
  logic [ADDR_W-1:0]     fault_region_base;
  logic [ADDR_W-1:0]     fault_address;

  int fail_count;
  int pending;
  int cycles = 0;
  int words_sent = 0;
  bit calm = 1'b0;

  logic [ADDR_W-1:0] pool_base [8];
  logic [ADDR_W-1:0] pool_len [8];
  int pool_next = 0;

  guarded_region_fault_catcher dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .address(address), .length(length),
    .out_valid(out_valid), .out_ready(out_ready),
    .verdict(verdict), .table_full(table_full), .fault_valid(fault_valid),
    .fault_region_base(fault_region_base), .fault_address(fault_address)
  );

  grfc_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .address(address), .length(length),
    .out_valid(out_valid), .out_ready(out_ready),
    .verdict(verdict), .table_full(table_full), .fault_valid(fault_valid),
    .fault_region_base(fault_region_base), .fault_address(fault_address),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] near_addr(int idx);
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] n;
    b = pool_base[idx];
    n = pool_len[idx];
    case ($urandom_range(0, 4))
      0: return b;
      1: return b + n - ADDR_W'(1);
      2: return b + n;
      3: return b - ADDR_W'(1);
      default: return (n == '0) ? b : b + (rand64() % n);
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      return near_addr($urandom_range(0, 7));
    if (r < 65)
      return rand64();
    if (r < 80) begin
      case ($urandom_range(0, 4))
        0: return '0;
        1: return ALL_ONES;
        2: return 64'd1;
        3: return 64'h8000_0000_0000_0000;
        default: return ALL_ONES - ADDR_W'(1);
      endcase
    end
    return ADDR_W'($urandom_range(0, 4095));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_base();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)
      return {32'h0, $urandom} & ~64'h3f;
    if (r < 70)
      return ALL_ONES - ADDR_W'($urandom_range(0, 1023));
    if (r < 78)
      return '0;
    return rand64();
  endfunction

  function automatic logic [ADDR_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      return ADDR_W'($urandom_range(1, 256));
    if (r < 55)
      return '0;
    if (r < 70)
      return rand64();
    if (r < 80)
      return ALL_ONES;
    if (r < 92)
      return {32'h0, $urandom};
    return 64'd1;
  endfunction

  task automatic send_word(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] a,
                           logic [ADDR_W-1:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    address <= a;
    length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_register(logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] n);
    pool_base[pool_next] = b;
    pool_len[pool_next] = n;
    pool_next = (pool_next + 1) % 8;
    send_word(ACT_REGISTER, b, n);
  endtask

  task automatic catch_scope();
    int latest;
    bit ended;
    send_word(ACT_START, rand64(), rand64());
    send_register(pick_base(), pick_len());
    latest = (pool_next + 7) % 8;
    ended = 1'b0;
    repeat ($urandom_range(1, 4)) begin
      if (!ended && $urandom_range(0, 5) == 0) begin
        send_word(ACT_END, rand64(), rand64());
        ended = 1'b1;
      end
      send_word(ACT_FAULT, ($urandom_range(0, 1) != 0) ? near_addr(latest) : pick_addr(),
                rand64());
    end
    if ($urandom_range(0, 3) != 0)
      send_word(ACT_CHECK, rand64(), rand64());
    if ($urandom_range(0, 2) != 0)
      send_word(ACT_UNREGISTER, near_addr(latest), rand64());
    if (!ended)
      send_word(ACT_END, rand64(), rand64());
  endtask

  task automatic noise_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)
      send_register(pick_base(), pick_len());
    else if (r < 30)
      send_word(ACT_UNREGISTER, pick_addr(), rand64());
    else if (r < 55)
      send_word(ACT_FAULT, pick_addr(), rand64());
    else if (r < 67)
      send_word(ACT_START, rand64(), rand64());
    else if (r < 79)
      send_word(ACT_END, rand64(), rand64());
    else if (r < 93)
      send_word(ACT_CHECK, rand64(), rand64());
    else
      send_word(($urandom_range(0, 1) != 0) ? ACT_SPARE_LO : ACT_SPARE_HI, rand64(), rand64());
  endtask

  initial begin
    int hold;
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    int limit_words;
    int i;
    for (i = 0; i < 8; i++) begin
      pool_base[i] = 64'h1000;
      pool_len[i] = 64'h100;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty table, empty latch, empty region
    send_word(ACT_CHECK, ALL_ONES, ALL_ONES);
    send_word(ACT_FAULT, 64'h1000, '0);
    send_word(ACT_REGISTER, '0, '0);
    send_word(ACT_REGISTER, 64'h1000, 64'h100);
    send_word(ACT_FAULT, 64'h1000, '0);
    send_word(ACT_START, '0, '0);
    send_word(ACT_FAULT, 64'h10ff, '0);
    send_word(ACT_FAULT, 64'h1100, '0);
    // overlap, latch busy
    send_word(ACT_REGISTER, 64'h1080, 64'h100);
    send_word(ACT_FAULT, 64'h1090, ALL_ONES);
    send_word(ACT_CHECK, '0, '0);
    send_word(ACT_CHECK, '0, '0);
    // range end past 64 bits
    send_word(ACT_REGISTER, 64'hffff_ffff_ffff_ff00, ALL_ONES);
    send_word(ACT_FAULT, ALL_ONES, '0);
    send_word(ACT_REGISTER, '0, 64'h10);
    send_word(ACT_REGISTER, 64'h5000, 64'h10);
    send_word(ACT_CHECK, '0, '0);
    send_word(ACT_UNREGISTER, 64'h10a0, '0);
    send_word(ACT_FAULT, '0, '0);
    send_word(ACT_CHECK, '0, '0);
    send_word(ACT_END, '0, '0);
    send_word(ACT_END, '0, '0);
    send_word(ACT_FAULT, 64'h5, '0);
    send_word(ACT_SPARE_LO, ALL_ONES, ALL_ONES);
    send_word(ACT_SPARE_HI, ALL_ONES, ALL_ONES);
    send_word(ACT_UNREGISTER, ALL_ONES, '0);
    send_word(ACT_UNREGISTER, '0, '0);

    limit_words = words_sent + RANDOM_WORDS;
    while (words_sent < limit_words) begin
      calm = ((words_sent / 200) % 3) == 1;
      if ($urandom_range(0, 99) < 70)
        catch_scope();
      else
        noise_word();
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
